[src/ght_pkg.sv]
// package: table geometry, op codes, state type and control structs for the handle table
`default_nettype none
package ght_pkg;

    localparam int TEXTURE_ENTRIES = 64;
    localparam int BUFFER_ENTRIES  = 64;
    localparam int SAMPLER_ENTRIES = 64;
    localparam int TOTAL_ENTRIES   = TEXTURE_ENTRIES + BUFFER_ENTRIES + SAMPLER_ENTRIES;

    localparam int TEXTURE_BASE = 0;
    localparam int BUFFER_BASE  = TEXTURE_ENTRIES;
    localparam int SAMPLER_BASE = TEXTURE_ENTRIES + BUFFER_ENTRIES;

    localparam int MAX_ENTRIES_TB = (TEXTURE_ENTRIES > BUFFER_ENTRIES) ?
                                    TEXTURE_ENTRIES : BUFFER_ENTRIES;
    localparam int MAX_ENTRIES    = (MAX_ENTRIES_TB > SAMPLER_ENTRIES) ?
                                    MAX_ENTRIES_TB : SAMPLER_ENTRIES;

    localparam int POS_W = $clog2(TOTAL_ENTRIES);
    localparam int IDX_W = $clog2(MAX_ENTRIES);

    localparam logic [31:0] COUNT_LIMIT = 32'hfffffff0;

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RETAIN  = 2'd1,
        OP_RELEASE = 2'd2,
        OP_QUERY   = 2'd3
    } ght_op_t;

    localparam logic [1:0] TBL_TEXTURE = 2'd0;
    localparam logic [1:0] TBL_BUFFER  = 2'd1;
    localparam logic [1:0] TBL_SAMPLER = 2'd2;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } ght_state_t;

    // live bit update from the control path
    typedef struct packed {
        logic set_en;
        logic clr_en;
        pos_t pos;
    } ght_live_cmd_t;

    // entry memory write port
    typedef struct packed {
        logic        en;
        pos_t        addr;
        logic [31:0] count;
        logic [31:0] gen;
    } ght_ram_wr_t;

    // base offset of a table in the shared store
    function automatic pos_t ght_base(input logic [1:0] tid);
        pos_t b;
        b = '0;
        unique case (tid)
            TBL_TEXTURE: b = POS_W'(TEXTURE_BASE);
            TBL_BUFFER:  b = POS_W'(BUFFER_BASE);
            TBL_SAMPLER: b = POS_W'(SAMPLER_BASE);
            default:     b = '0;
        endcase
        return b;
    endfunction

    // entry count of a table, zero for an unknown table
    function automatic logic [31:0] ght_size(input logic [1:0] tid);
        logic [31:0] s;
        s = '0;
        unique case (tid)
            TBL_TEXTURE: s = 32'(TEXTURE_ENTRIES);
            TBL_BUFFER:  s = 32'(BUFFER_ENTRIES);
            TBL_SAMPLER: s = 32'(SAMPLER_ENTRIES);
            default:     s = '0;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

[src/ght_live_map.sv]
// in-use bits of all entries and the lowest-free-entry search per table
`default_nettype none
module ght_live_map (
    input  wire                   clk,
    input  wire                   rst_n,
    input  ght_pkg::ght_live_cmd_t cmd,
    input  wire  [1:0]            table_id,
    input  ght_pkg::pos_t         rd_pos,
    output logic                  found,
    output ght_pkg::idx_t         free_idx,
    output logic                  rd_live
);
    import ght_pkg::*;

    logic [TOTAL_ENTRIES-1:0] live_reg;
    logic tex_found, buf_found, smp_found;
    idx_t tex_idx, buf_idx, smp_idx;

    // live bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
        end
        else
        begin
            if (cmd.set_en)
            begin
                live_reg[cmd.pos] <= 1'b1;
            end
            else if (cmd.clr_en)
            begin
                live_reg[cmd.pos] <= 1'b0;
            end
        end
    end

    // lowest free entry from index 1 upward, one encoder per table
    always_comb
    begin
        tex_found = 1'b0;
        buf_found = 1'b0;
        smp_found = 1'b0;
        tex_idx   = '0;
        buf_idx   = '0;
        smp_idx   = '0;
        for (int i = MAX_ENTRIES - 1; i >= 1; i--)
        begin
            if (i < TEXTURE_ENTRIES && !live_reg[POS_W'(TEXTURE_BASE + i)])
            begin
                tex_found = 1'b1;
                tex_idx   = IDX_W'(i);
            end
            if (i < BUFFER_ENTRIES && !live_reg[POS_W'(BUFFER_BASE + i)])
            begin
                buf_found = 1'b1;
                buf_idx   = IDX_W'(i);
            end
            if (i < SAMPLER_ENTRIES && !live_reg[POS_W'(SAMPLER_BASE + i)])
            begin
                smp_found = 1'b1;
                smp_idx   = IDX_W'(i);
            end
        end
    end

    // table select
    always_comb
    begin
        found    = 1'b0;
        free_idx = '0;
        unique case (table_id)
            TBL_TEXTURE:
            begin
                found    = tex_found;
                free_idx = tex_idx;
            end
            TBL_BUFFER:
            begin
                found    = buf_found;
                free_idx = buf_idx;
            end
            TBL_SAMPLER:
            begin
                found    = smp_found;
                free_idx = smp_idx;
            end
            default:
            begin
                found    = 1'b0;
                free_idx = '0;
            end
        endcase
    end

    assign rd_live = live_reg[rd_pos];

endmodule
`default_nettype wire

[src/ght_entry_ram.sv]
// count and generation memory with written flags so untouched entries read as zero
`default_nettype none
module ght_entry_ram (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  rd_en,
    input  ght_pkg::pos_t        rd_addr,
    input  ght_pkg::ght_ram_wr_t wr,
    output logic [31:0]          rd_count,
    output logic [31:0]          rd_gen
);
    import ght_pkg::*;

    logic [63:0]              mem [TOTAL_ENTRIES];
    logic [TOTAL_ENTRIES-1:0] written_reg;
    logic [63:0]              rd_data_reg;
    logic                     rd_written_reg;

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= {wr.count, wr.gen};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // written flags stand in for the cleared reset contents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                written_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_count = rd_written_reg ? rd_data_reg[63:32] : 32'd0;
    assign rd_gen   = rd_written_reg ? rd_data_reg[31:0]  : 32'd0;

endmodule
`default_nettype wire

[src/generational_handle_table.sv]
// top level: request sequencer doing one entry read per beat, written back on a successful alloc, retain or release
// done is registered from the modify/write state, which follows the accepting edge
// each beat is an entry memory read, then a modify/write; no new beat is taken during the modify/write
// busy is high only during the modify/write cycle; start may be taken while done shows
// results are strobed for one cycle; the receiver cannot stall
// reset: asynchronous; live bits and written flags clear at once, no clearing pass
`default_nettype none
module generational_handle_table (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  kind,
    input  wire  [1:0]  table_id,
    input  wire  [31:0] handle_index,
    input  wire  [31:0] handle_generation,
    output logic        done,
    output logic        valid_res,
    output logic [31:0] result_index,
    output logic [31:0] result_generation,
    output logic [31:0] result_slot
);
    import ght_pkg::*;

    ght_state_t state_reg, state_next;

    ght_live_cmd_t live_cmd;
    ght_ram_wr_t   ram_wr;
    logic          accept;
    logic          found;
    idx_t          free_idx;
    logic          rd_live;
    logic [31:0]   rd_count;
    logic [31:0]   rd_gen;
    pos_t          acc_pos;

    // request registers captured on accept
    ght_op_t     op_reg;
    logic        tid_ok_reg;
    logic        hit_ok_reg;
    logic        found_reg;
    logic        live_reg;
    pos_t        pos_reg;
    idx_t        free_idx_reg;
    logic [31:0] hidx_reg;
    logic [31:0] hgen_reg;

    // result registers
    logic        done_reg, done_next;
    logic        valid_reg, valid_next;
    logic [31:0] index_reg, index_next;
    logic [31:0] gen_reg, gen_next;
    logic [31:0] slot_reg, slot_next;

    logic [31:0] gen_inc;
    logic [31:0] cnt_dec;

    assign accept = start && !busy;

    // entry position of the beat being accepted
    always_comb
    begin
        if (ght_op_t'(kind) == OP_ALLOC)
        begin
            acc_pos = ght_base(table_id) + POS_W'(free_idx);
        end
        else
        begin
            acc_pos = ght_base(table_id) + POS_W'(handle_index);
        end
    end

    ght_live_map u_live (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (live_cmd),
        .table_id (table_id),
        .rd_pos   (acc_pos),
        .found    (found),
        .free_idx (free_idx),
        .rd_live  (rd_live)
    );

    ght_entry_ram u_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (acc_pos),
        .wr       (ram_wr),
        .rd_count (rd_count),
        .rd_gen   (rd_gen)
    );

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        busy = 1'b0;
        unique case (state_reg)
            ST_IDLE: busy = 1'b0;
            ST_EXEC: busy = 1'b1;
            default: busy = 1'b0;
        endcase
    end

    // capture the request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= ght_op_t'(kind);
            tid_ok_reg   <= (ght_size(table_id) != 32'd0);
            hit_ok_reg   <= !(handle_index == 32'd0 && handle_generation == 32'd0)
                            && (handle_index < ght_size(table_id));
            found_reg    <= found;
            live_reg     <= rd_live;
            pos_reg      <= acc_pos;
            free_idx_reg <= free_idx;
            hidx_reg     <= handle_index;
            hgen_reg     <= handle_generation;
        end
    end

    // generation bump skipping zero, decrement saturating at zero
    assign gen_inc = (rd_gen == 32'hffffffff) ? 32'd1 : rd_gen + 32'd1;
    assign cnt_dec = (rd_count != 32'd0) ? rd_count - 32'd1 : rd_count;

    // modify and write back
    always_comb
    begin
        live_cmd   = '0;
        ram_wr     = '0;
        done_next  = 1'b0;
        valid_next = 1'b0;
        index_next = '0;
        gen_next   = '0;
        slot_next  = '0;
        live_cmd.pos = pos_reg;
        ram_wr.addr  = pos_reg;
        if (state_reg == ST_EXEC)
        begin
            done_next = 1'b1;
            if (op_reg == OP_ALLOC)
            begin
                if (tid_ok_reg && found_reg)
                begin
                    live_cmd.set_en = 1'b1;
                    ram_wr.en       = 1'b1;
                    ram_wr.count    = 32'd1;
                    ram_wr.gen      = gen_inc;
                    valid_next      = 1'b1;
                    index_next      = 32'(free_idx_reg);
                    gen_next        = gen_inc;
                    slot_next       = 32'(free_idx_reg);
                end
            end
            else if (tid_ok_reg && hit_ok_reg && live_reg && rd_gen == hgen_reg)
            begin
                valid_next   = 1'b1;
                ram_wr.gen   = rd_gen;
                ram_wr.count = rd_count;
                case (op_reg)
                    OP_RETAIN:
                    begin
                        ram_wr.en = 1'b1;
                        if (rd_count < COUNT_LIMIT)
                        begin
                            ram_wr.count = rd_count + 32'd1;
                        end
                    end
                    OP_RELEASE:
                    begin
                        ram_wr.en    = 1'b1;
                        ram_wr.count = cnt_dec;
                        if (cnt_dec == 32'd0)
                        begin
                            live_cmd.clr_en = 1'b1;
                        end
                    end
                    default:
                    begin
                        slot_next = hidx_reg;
                    end
                endcase
            end
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        valid_reg <= valid_next;
        index_reg <= index_next;
        gen_reg   <= gen_next;
        slot_reg  <= slot_next;
    end

    assign done              = done_reg;
    assign valid_res         = valid_reg;
    assign result_index      = index_reg;
    assign result_generation = gen_reg;
    assign result_slot       = slot_reg;

endmodule
`default_nettype wire

[src/ght_checker.sv]
// port-level checker for the handle table and its bind
`default_nettype none
module ght_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        start,
    input wire        busy,
    input wire        done,
    input wire        valid_res,
    input wire [31:0] result_index,
    input wire [31:0] result_generation,
    input wire [31:0] result_slot
);

    // an accepted beat makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // every accepted beat raises done after its modify/write cycle
    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 done)
        else $error("result strobe missing");

    // a result only shows once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // failed beats carry an all-zero payload
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !valid_res |-> result_index == 32'd0 && result_generation == 32'd0
                               && result_slot == 32'd0)
        else $error("nonzero payload on failure");

    // an allocation reports slot equal to index and a nonzero generation
    a_alloc_shape: assert property (@(posedge clk) disable iff (!rst_n)
        done && valid_res && result_index != 32'd0 |->
            result_slot == result_index && result_generation != 32'd0)
        else $error("allocation result malformed");

endmodule

bind generational_handle_table ght_checker u_ght_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .done              (done),
    .valid_res         (valid_res),
    .result_index      (result_index),
    .result_generation (result_generation),
    .result_slot       (result_slot)
);
`default_nettype wire
